### sv/mkq_pkg.sv
// Shared types and codes for the k-th neighbor multiset block.
`default_nettype none
package mkq_pkg;
  localparam int unsigned ValueBits = 60;
  localparam int unsigned RankBits  = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_KTH_LE = 2'd1,
    OP_KTH_GE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_WALK,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

### sv/multiset_kth_neighbor_query.sv
// Top level of the k-th neighbor multiset: sorted key/count table in one memory.
//
//  channel | dir | tdata (low bit up)
//  s_axis  | in  | operation[1:0], value[61:2], rank[69:62], zero pad to 72
//  m_axis  | out | status[1:0], answer[61:2], zero pad to 64
//
// One item at a time. A lookup is a binary search over the table, one memory
// read per halving: about log2(TABLE_DEPTH)+1 reads. A query then walks up to
// rank entries. An insert of a new key shifts every entry above its place up
// by one.
// Reset empties the table at once (the fill count goes to zero); no clearing pass.
// The result sits in an output register; a stalled m_axis holds the next item off.
`default_nettype none
module multiset_kth_neighbor_query #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // operation, value, rank
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // status, answer
);
  import mkq_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = ValueBits + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [NW-1:0] Full = NW'(TABLE_DEPTH);

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  state_e state_q, state_d;
  op_e    op_q;
  logic [ValueBits-1:0] val_q;
  logic [RankBits-1:0]  rank_q;
  logic [NW-1:0] used_q, used_d;
  logic [NW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [NW-1:0] mid_q, mid_d;
  logic [NW-1:0] p_q, p_d;
  logic          pend_q, pend_d;     // a read was issued last cycle
  logic [RankBits:0] sum_q, sum_d;   // kept below rank; not updated once rank is reached
  logic [1:0]    st_q, st_d;
  logic [ValueBits-1:0] ans_q, ans_d;
  logic          ov_q, ov_d;

  logic [ValueBits-1:0]  rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [NW+COUNT_BITS:0] sum_wide;
  assign rd_key = rd_q[ValueBits-1:0];
  assign rd_cnt = rd_q[EW-1:ValueBits];
  assign sum_wide = (NW+COUNT_BITS+1)'(sum_q) + (NW+COUNT_BITS+1)'(rd_cnt);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, ans_q, st_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid && s_axis_tready) begin
        state_d = S_SRCH;
      end
      S_SRCH:   if (!pend_q && lo_q >= hi_q) begin
        state_d = S_DECIDE;
      end
      S_DECIDE: if (!pend_q) begin
        state_d = (op_q == OP_INSERT) ? S_SHIFT : S_WALK;
      end
      S_WALK:   if (st_d != st_q || (!pend_q && p_q == p_d && sum_q == sum_d)) begin
        state_d = S_DONE;
      end
      S_SHIFT:  if (p_q == mid_q && !pend_q) begin
        state_d = S_WRITE;
      end
      S_WRITE:  state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; p_d = p_q; pend_d = 1'b0;
    sum_d = sum_q; st_d = st_q; ans_d = ans_q; used_d = used_q; ov_d = ov_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        // The previous result stays put until the next beat is taken in.
        if (s_axis_tvalid && s_axis_tready) begin
          lo_d = '0; hi_d = used_q; sum_d = '0;
          st_d = ST_NOT_FOUND; ans_d = '0;
        end
      end
      S_SRCH: begin
        if (pend_q) begin
          if (rd_key < val_q) begin
            lo_d = mid_q + NW'(1);
          end else begin
            hi_d = mid_q;
          end
        end else if (lo_q < hi_q) begin
          mid_d = lo_q + ((hi_q - lo_q) >> 1);
          rd_en = 1'b1; rd_addr = AW'(lo_q + ((hi_q - lo_q) >> 1));
          pend_d = 1'b1;
        end else if (lo_q < used_q) begin
          rd_en = 1'b1; rd_addr = AW'(lo_q); pend_d = 1'b1;
        end
      end
      S_DECIDE: begin
        // mid_q doubles as the lower-bound position here; p_q is walk or shift index.
        mid_d = lo_q;
        if (op_q == OP_INSERT) begin
          if (lo_q < used_q && rd_key == val_q) begin
            st_d = ST_OK;
            wr_en = 1'b1; wr_addr = AW'(lo_q);
            wr_data = {(rd_cnt == CountMax) ? rd_cnt : rd_cnt + COUNT_BITS'(1), rd_key};
            p_d = lo_q;
          end else if (used_q >= Full) begin
            st_d = ST_FULL; p_d = lo_q;
          end else begin
            st_d = ST_OK; p_d = used_q;
          end
        end else if (op_q == OP_KTH_LE) begin
          p_d = (lo_q < used_q && rd_key == val_q) ? lo_q + NW'(1) : lo_q;
        end else begin
          p_d = lo_q;
        end
        if ((op_q == OP_KTH_LE || op_q == OP_KTH_GE) && rank_q == '0) begin
          p_d = (op_q == OP_KTH_LE) ? '0 : used_q;
        end
        if (op_q == OP_NONE) begin
          p_d = used_q;
        end
      end
      S_WALK: begin
        if (pend_q) begin
          if (sum_wide >= (NW+COUNT_BITS+1)'(rank_q)) begin
            st_d = ST_OK; ans_d = rd_key;
          end else begin
            sum_d = sum_wide[RankBits:0];
          end
        end else if (op_q == OP_KTH_LE && p_q != '0) begin
          p_d = p_q - NW'(1);
          rd_en = 1'b1; rd_addr = AW'(p_q - NW'(1)); pend_d = 1'b1;
        end else if (op_q == OP_KTH_GE && p_q < used_q) begin
          p_d = p_q + NW'(1);
          rd_en = 1'b1; rd_addr = AW'(p_q); pend_d = 1'b1;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          wr_en = 1'b1; wr_addr = AW'(p_q); wr_data = rd_q;
          p_d = p_q - NW'(1);
        end else if (p_q != mid_q) begin
          rd_en = 1'b1; rd_addr = AW'(p_q - NW'(1)); pend_d = 1'b1;
        end
      end
      S_WRITE: begin
        if (st_q == ST_OK && !(p_q == mid_q && used_q >= Full) &&
            !(mid_q < used_q && rd_key == val_q)) begin
          wr_en = 1'b1; wr_addr = AW'(mid_q);
          wr_data = {COUNT_BITS'(1), val_q};
          used_d = used_q + NW'(1);
        end
      end
      S_DONE: begin
        ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= op_e'(s_axis_tdata[1:0]);
      val_q  <= s_axis_tdata[61:2];
      rank_q <= s_axis_tdata[69:62];
    end
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; p_q <= p_d;
    sum_q <= sum_d; st_q <= st_d; ans_q <= ans_d;
  end

  property p_full_stable;
    @(posedge clk_i) disable iff (!rst_ni) used_q <= Full;
  endproperty
  a_used: assert property (p_full_stable) else $error("fill count above depth");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + NW'(1)))
    else $error("fill count jumped");
endmodule
`default_nettype wire
